>>> hdl/two_range_trilateration_top_macros.svh
`ifndef TWO_RANGE_TRILATERATION_TOP_MACROS_SVH
`define TWO_RANGE_TRILATERATION_TOP_MACROS_SVH
// Implication checked on every rising edge of clk, switched off during rst.
`define TRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Condition that must never be seen on a rising edge of clk outside of rst.
`define TRT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

>>> hdl/trt_pkg.sv
`timescale 1ns / 1ps
package trt_pkg;
  // Width of every length.
  localparam int LEN_BITS = 16;
  // Width of the squared sums and the numerator of x.
  localparam int NUM_BITS = 2 * LEN_BITS + 1;
  // Front end 3, divider LEN_BITS, remainder 2, root LEN_BITS, output 1.
  localparam int LATENCY = 2 * LEN_BITS + 6;

  // Carried alongside the divider.
  typedef struct packed {
    logic                    ok;
    logic                    neg;
    logic [2*LEN_BITS-1:0]   bsq;
  } trt_side_t;

  // Carried alongside the square root.
  typedef struct packed {
    logic                ok;
    logic                neg;
    logic [LEN_BITS-1:0] mag;
  } trt_xs_t;
endpackage

>>> hdl/trt_front.sv
`timescale 1ns / 1ps
module trt_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [trt_pkg::LEN_BITS-1:0]      a,
  input  logic [trt_pkg::LEN_BITS-1:0]      b,
  input  logic [trt_pkg::LEN_BITS-1:0]      c,
  output logic                              out_valid,
  output logic [trt_pkg::NUM_BITS-1:0]      num,
  output logic [trt_pkg::LEN_BITS:0]        div,
  output trt_pkg::trt_side_t                side
);
  import trt_pkg::*;

  localparam int LB = LEN_BITS;

  logic              v1, v2;
  logic [LB-1:0]     a1, b1, c1;
  logic              ok1, ok2;
  logic [2*LB-1:0]   asq2, bsq2, csq2;
  logic [LB-1:0]     c2;
  logic [LB:0]       sab, sac, sbc;
  logic              ok_next;
  logic [NUM_BITS-1:0] pos, asq_ext;

  // Strict triangle inequalities on the raw lengths.
  always_comb begin
    sab = {1'b0, a} + {1'b0, b};
    sac = {1'b0, a} + {1'b0, c};
    sbc = {1'b0, b} + {1'b0, c};
    ok_next = (sab > {1'b0, c}) && (sac > {1'b0, b}) && (sbc > {1'b0, a});
  end

  // Valid bits of the three front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // Stage one captures the item, stage two forms the squares.
  always_ff @(posedge clk) begin
    a1   <= a;
    b1   <= b;
    c1   <= c;
    ok1  <= ok_next;
    asq2 <= a1 * a1;
    bsq2 <= b1 * b1;
    csq2 <= c1 * c1;
    c2   <= c1;
    ok2  <= ok1;
  end

  // Stage three forms |b^2 + c^2 - a^2| with its sign and the divisor 2c.
  always_comb begin
    pos     = {1'b0, bsq2} + {1'b0, csq2};
    asq_ext = {1'b0, asq2};
  end

  always_ff @(posedge clk) begin
    if (pos >= asq_ext) begin
      num      <= pos - asq_ext;
      side.neg <= 1'b0;
    end else begin
      num      <= asq_ext - pos;
      side.neg <= 1'b1;
    end
    div      <= {c2, 1'b0};
    side.ok  <= ok2;
    side.bsq <= bsq2;
  end
endmodule

>>> hdl/trt_div.sv
`timescale 1ns / 1ps
module trt_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [trt_pkg::NUM_BITS-1:0]      num,
  input  logic [trt_pkg::LEN_BITS:0]        div,
  input  trt_pkg::trt_side_t                in_side,
  output logic                              out_valid,
  output logic [trt_pkg::LEN_BITS-1:0]      quot,
  output trt_pkg::trt_side_t                out_side
);
  import trt_pkg::*;

  localparam int LB = LEN_BITS;

  // Slot 0 is the incoming item, slot k holds it after k quotient bits.
  logic          vld  [0:LB];
  logic [LB:0]   rem  [0:LB];
  logic [LB-1:0] low  [0:LB];
  logic [LB-1:0] qt   [0:LB];
  logic [LB:0]   dv   [0:LB];
  trt_side_t     sd   [0:LB];

  // For a valid triangle the quotient fits LB bits, so the top bits of the
  // numerator are already below the divisor.
  always_comb begin
    vld[0] = in_valid;
    rem[0] = num[NUM_BITS-1:LB];
    low[0] = num[LB-1:0];
    qt[0]  = '0;
    dv[0]  = div;
    sd[0]  = in_side;
  end

  // One restoring step per stage.
  for (genvar k = 0; k < LB; k++) begin : g_step
    logic [LB+1:0] trial;
    logic [LB+1:0] diff;
    logic          take;

    always_comb begin
      trial = {rem[k], low[k][LB-1]};
      diff  = trial - {1'b0, dv[k]};
      take  = trial >= {1'b0, dv[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (take) begin
        rem[k+1] <= diff[LB:0];
      end else begin
        rem[k+1] <= trial[LB:0];
      end
      low[k+1] <= {low[k][LB-2:0], 1'b0};
      qt[k+1]  <= {qt[k][LB-2:0], take};
      dv[k+1]  <= dv[k];
      sd[k+1]  <= sd[k];
    end
  end

  assign out_valid = vld[LB];
  assign quot      = qt[LB];
  assign out_side  = sd[LB];
endmodule

>>> hdl/trt_rem.sv
`timescale 1ns / 1ps
module trt_rem (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [trt_pkg::LEN_BITS-1:0]      mag,
  input  trt_pkg::trt_side_t                in_side,
  output logic                              out_valid,
  output logic [2*trt_pkg::LEN_BITS-1:0]    rad,
  output trt_pkg::trt_xs_t                  out_xs
);
  import trt_pkg::*;

  localparam int LB = LEN_BITS;

  logic            v1;
  logic [2*LB-1:0] msq1, bsq1;
  trt_xs_t         xs1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  // Square x, then take it from b^2; |x| < b keeps the difference positive.
  always_ff @(posedge clk) begin
    msq1   <= mag * mag;
    bsq1   <= in_side.bsq;
    xs1    <= '{ok: in_side.ok, neg: in_side.neg, mag: mag};
    rad    <= bsq1 - msq1;
    out_xs <= xs1;
  end
endmodule

>>> hdl/trt_sqrt.sv
`timescale 1ns / 1ps
module trt_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [2*trt_pkg::LEN_BITS-1:0]    rad,
  input  trt_pkg::trt_xs_t                  in_xs,
  output logic                              out_valid,
  output logic [trt_pkg::LEN_BITS-1:0]      root,
  output trt_pkg::trt_xs_t                  out_xs
);
  import trt_pkg::*;

  localparam int LB = LEN_BITS;

  // Slot k holds the item after k root bits.
  logic            vld [0:LB];
  logic [LB+1:0]   rm  [0:LB];
  logic [2*LB-1:0] src [0:LB];
  logic [LB-1:0]   rt  [0:LB];
  trt_xs_t         xs  [0:LB];

  always_comb begin
    vld[0] = in_valid;
    rm[0]  = '0;
    src[0] = rad;
    rt[0]  = '0;
    xs[0]  = in_xs;
  end

  // One root bit per stage from the next two radicand bits.
  for (genvar k = 0; k < LB; k++) begin : g_step
    logic [LB+3:0] trial;
    logic [LB+3:0] test;
    logic [LB+3:0] diff;
    logic          take;

    always_comb begin
      trial = {rm[k], src[k][2*LB-1:2*LB-2]};
      test  = {2'b00, rt[k], 2'b01};
      diff  = trial - test;
      take  = trial >= test;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (take) begin
        rm[k+1] <= diff[LB+1:0];
      end else begin
        rm[k+1] <= trial[LB+1:0];
      end
      src[k+1] <= {src[k][2*LB-3:0], 2'b00};
      rt[k+1]  <= {rt[k][LB-2:0], take};
      xs[k+1]  <= xs[k];
    end
  end

  assign out_valid = vld[LB];
  assign root      = rt[LB];
  assign out_xs    = xs[LB];
endmodule

>>> hdl/two_range_trilateration_top.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// input     range_first, range_second, baseline     start high and busy low
// result    pos_x, pos_y, valid_res                 done high for one cycle
//
// One item may enter in every cycle; busy stays low.
// Each result passes through the one-bit-per-stage divider and
// square root pipelines.
// Synchronous reset clears the valid bits; items in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`include "two_range_trilateration_top_macros.svh"
module two_range_trilateration_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [trt_pkg::LEN_BITS-1:0]      range_first,
  input  logic [trt_pkg::LEN_BITS-1:0]      range_second,
  input  logic [trt_pkg::LEN_BITS-1:0]      baseline,
  output logic                              done,
  output logic signed [trt_pkg::LEN_BITS:0] pos_x,
  output logic [trt_pkg::LEN_BITS-1:0]      pos_y,
  output logic                              valid_res
);
  import trt_pkg::*;

  localparam int LB = LEN_BITS;

  logic                f_valid, d_valid, r_valid, s_valid;
  logic [NUM_BITS-1:0] f_num;
  logic [LB:0]         f_div;
  trt_side_t           f_side, d_side;
  logic [LB-1:0]       d_quot, s_root;
  logic [2*LB-1:0]     r_rad;
  trt_xs_t             r_xs, s_xs;

  assign busy = 1'b0;

  trt_front u_front (
    .clk(clk), .rst(rst), .in_valid(start),
    .a(range_first), .b(range_second), .c(baseline),
    .out_valid(f_valid), .num(f_num), .div(f_div), .side(f_side)
  );

  trt_div u_div (
    .clk(clk), .rst(rst), .in_valid(f_valid), .num(f_num), .div(f_div),
    .in_side(f_side), .out_valid(d_valid), .quot(d_quot), .out_side(d_side)
  );

  trt_rem u_rem (
    .clk(clk), .rst(rst), .in_valid(d_valid), .mag(d_quot), .in_side(d_side),
    .out_valid(r_valid), .rad(r_rad), .out_xs(r_xs)
  );

  trt_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_valid(r_valid), .rad(r_rad), .in_xs(r_xs),
    .out_valid(s_valid), .root(s_root), .out_xs(s_xs)
  );

  // Output register: apply the sign of x and zero out non-triangles.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    valid_res <= s_xs.ok;
    if (!s_xs.ok) begin
      pos_x <= '0;
      pos_y <= '0;
    end else begin
      pos_y <= s_root;
      if (s_xs.neg) begin
        pos_x <= -$signed({1'b0, s_xs.mag});
      end else begin
        pos_x <= $signed({1'b0, s_xs.mag});
      end
    end
  end

  `TRT_ASSERT_IMPL(a_latency, start, ##LATENCY done, "item result did not arrive on time")
  `TRT_ASSERT_IMPL(a_no_spurious, !start, ##LATENCY !done, "result without an item")
  `TRT_ASSERT_IMPL(a_invalid_zero, done && !valid_res, pos_x == 0 && pos_y == 0,
    "non-triangle result not zero")
  `TRT_ASSERT_NEVER(a_busy, busy, "busy raised")
endmodule

>>> verif/trt_checker.sv
`timescale 1ns / 1ps
module trt_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [trt_pkg::LEN_BITS-1:0]      range_first,
  input  logic [trt_pkg::LEN_BITS-1:0]      range_second,
  input  logic [trt_pkg::LEN_BITS-1:0]      baseline,
  input  logic                              done,
  input  logic signed [trt_pkg::LEN_BITS:0] pos_x,
  input  logic [trt_pkg::LEN_BITS-1:0]      pos_y,
  input  logic                              valid_res,
  output int                                fail_count,
  output int                                pending
);
  import trt_pkg::*;

  typedef struct {
    logic signed [LEN_BITS:0] x;
    logic [LEN_BITS-1:0]      y;
    logic                     ok;
  } position_t;

  position_t position_q[$];

  // Floor of the square root, one result bit per step.
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Exact integer position from the two ranges and the baseline.
  function automatic position_t locate(input logic [LEN_BITS-1:0] ra,
                                       input logic [LEN_BITS-1:0] rb,
                                       input logic [LEN_BITS-1:0] rc);
    position_t p;
    logic [63:0] a, b, c, num_pos, num_neg, mag, r;
    a = ra;
    b = rb;
    c = rc;
    p.x = '0;
    p.y = '0;
    p.ok = 1'b0;
    if (a + b <= c || a + c <= b || b + c <= a) return p;
    num_pos = b * b + c * c;
    num_neg = a * a;
    if (num_pos >= num_neg) begin
      mag = (num_pos - num_neg) / (2 * c);
      p.x = mag[LEN_BITS:0];
    end else begin
      mag = (num_neg - num_pos) / (2 * c);
      p.x = -$signed({1'b0, mag[LEN_BITS-1:0]});
    end
    r = isqrt(b * b - mag * mag);
    p.y = r[LEN_BITS-1:0];
    p.ok = 1'b1;
    return p;
  endfunction

  assign pending = position_q.size();

  // Predict on each accepted item; compare each result with the oldest one.
  always @(posedge clk) begin
    position_t e;
    if (rst) begin
      position_q.delete();
      fail_count <= 0;
    end else begin
      if (start && !busy) begin
        position_q = {position_q, locate(range_first, range_second, baseline)};
      end
      if (done) begin
        if (position_q.size() == 0) begin
          $display("%0t: result with no item waiting: x=%0d y=%0d ok=%0b",
                   $time, pos_x, pos_y, valid_res);
          fail_count <= fail_count + 1;
        end else begin
          e = position_q.pop_front();
          if (e.x !== pos_x || e.y !== pos_y || e.ok !== valid_res) begin
            $display("%0t: mismatch expected x=%0d y=%0d ok=%0b actual x=%0d y=%0d ok=%0b",
                     $time, e.x, e.y, e.ok, pos_x, pos_y, valid_res);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> verif/tb_two_range_trilateration_top.sv
`timescale 1ns / 1ps
module tb_two_range_trilateration_top;
  import trt_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [LEN_BITS-1:0]      range_first;
  logic [LEN_BITS-1:0]      range_second;
  logic [LEN_BITS-1:0]      baseline;
  logic                     done;
  logic signed [LEN_BITS:0] pos_x;
  logic [LEN_BITS-1:0]      pos_y;
  logic                     valid_res;
  int                       fail_count;
  int                       pending;
  int                       idle_pct;

  localparam logic [LEN_BITS-1:0] MAXL = '1;

  two_range_trilateration_top u_dut (.*);

  trt_checker u_chk (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input logic [LEN_BITS-1:0] a, input logic [LEN_BITS-1:0] b,
                           input logic [LEN_BITS-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    range_first <= a;
    range_second <= b;
    baseline <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly real triangles of mixed scale, with some arbitrary triples.
  task automatic send_random();
    logic [LEN_BITS-1:0] a, b, c;
    int lim;
    lim = ($urandom_range(9) < 2) ? 255 : ($urandom_range(3) == 0 ? 65535 : 32767);
    if ($urandom_range(9) < 3) begin
      a = LEN_BITS'($urandom);
      b = LEN_BITS'($urandom);
      c = LEN_BITS'($urandom);
    end else begin
      b = LEN_BITS'($urandom_range(lim, 1));
      c = LEN_BITS'($urandom_range(lim, 1));
      a = LEN_BITS'($urandom_range(
            int'(b) + int'(c) - 1 > 65535 ? 65535 : int'(b) + int'(c) - 1,
            (b > c ? b - c : c - b) + 1));
    end
    send_item(a, b, c);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    range_first = '0;
    range_second = '0;
    baseline = '0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zeros, degenerate triangles, extremes, both signs of x.
    send_item(0, 0, 0);
    send_item(3, 4, 0);
    send_item(5, 3, 4);
    send_item(3, 5, 4);
    send_item(4, 3, 5);
    send_item(7, 3, 4);
    send_item(1, 1, 1);
    send_item(MAXL, MAXL, MAXL);
    send_item(MAXL, MAXL, 1);
    send_item(1, MAXL, MAXL);
    send_item(MAXL, 1, MAXL);
    send_item(MAXL, MAXL - 1, 2);
    send_item(MAXL - 1, MAXL, 2);
    send_item(MAXL, MAXL, 0);
    send_item(16'h8000, 16'h7fff, 16'h0002);
    send_item(16'h5555, 16'haaaa, 16'haaaa);
    send_item(16'haaaa, 16'h5555, 16'h5556);
    send_item(10, 2, 9);
    send_item(2, 10, 9);

    // Random phases with changing idle rates.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1 ? 58 : (ph == 2 ? 29 : 0));
      repeat (110) send_random();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hdl
hdl/trt_pkg.sv
hdl/trt_front.sv
hdl/trt_div.sv
hdl/trt_rem.sv
hdl/trt_sqrt.sv
hdl/two_range_trilateration_top.sv
verif/trt_checker.sv
verif/tb_two_range_trilateration_top.sv
